@@ rtl/keyed_recent_first_table_macros.svh @@
// Assertion macros for the keyed recent-first table.
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef KEYED_RECENT_FIRST_TABLE_MACROS_SVH
`define KEYED_RECENT_FIRST_TABLE_MACROS_SVH

// Same-cycle implication.
`define KRFT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KRFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/krft_pkg.sv @@
// Package for the keyed recent-first table: field widths, operation codes,
// control state and the per-cell control struct. No dependencies.
package krft_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int KIND_W          = 2;
    localparam int KEY_W           = 16;
    localparam int VALUE_W         = 32;
    localparam int COUNT_W         = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_LOOKUP = 2'd2
    } kind_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic             capture;
        logic [KEY_W-1:0] probe_key;
        logic             do_insert;
        logic             do_remove;
    } cell_ctrl_t;

endpackage

@@ rtl/krft_req_if.sv @@
// Request channel of the keyed recent-first table: valid/ready and one operation.
// Depends on krft_pkg.
interface krft_req_if import krft_pkg::*;;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;

    modport source (output valid, kind, key, value, input ready);
    modport sink   (input valid, kind, key, value, output ready);
endinterface

@@ rtl/krft_rsp_if.sv @@
// Response channel of the keyed recent-first table: valid/ready and one result.
// Depends on krft_pkg.
interface krft_rsp_if import krft_pkg::*;;
    logic               valid;
    logic               ready;
    logic               found;
    logic [VALUE_W-1:0] found_value;
    logic [COUNT_W-1:0] entry_count;
    logic               overflow;

    modport source (output valid, found, found_value, entry_count, overflow, input ready);
    modport sink   (input valid, found, found_value, entry_count, overflow, output ready);
endinterface

@@ rtl/keyed_recent_first_table.sv @@
// Keyed recent-first table built as a row of cells, newest entry in cell 0.
// Request and per-cell compare are registered on accept; result at commit.
// One request at a time: capture compare, then commit shift, then the next.
// A waiting response stalls commit, and with it the next request.
// Reset (rst_n async low) empties the table and clears all handshake state.
module keyed_recent_first_table
    import krft_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    krft_req_if.sink   req,
    krft_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    state_t             state_reg, state_next;
    logic [KIND_W-1:0]  kind_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               out_valid_reg;
    logic               found_reg;
    logic [VALUE_W-1:0] found_value_reg;
    logic [COUNT_W-1:0] entry_count_reg;
    logic               overflow_reg;

    logic accept;
    logic commit;
    logic full;
    logic is_insert, is_remove, is_lookup;
    logic hit_any;
    logic ins_ok, rem_ok;
    logic [VALUE_W-1:0] hit_value;
    cell_ctrl_t ctrl;

    logic [KEY_W-1:0]   cell_key   [TABLE_DEPTH];
    logic [VALUE_W-1:0] cell_value [TABLE_DEPTH];
    logic               match_chain [TABLE_DEPTH+1];
    logic [VALUE_W-1:0] sel_chain   [TABLE_DEPTH+1];

    // state machine
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        commit    = 1'b0;
        case (state_reg)
            ST_IDLE: req.ready = 1'b1;
            ST_EXEC: commit    = !out_valid_reg || rsp.ready;
            default:
            begin
                req.ready = 1'b0;
                commit    = 1'b0;
            end
        endcase
    end

    assign accept = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= req.kind;
            key_reg   <= req.key;
            value_reg <= req.value;
        end
    end

    assign full      = cnt_reg == CNT_W'(TABLE_DEPTH);
    assign is_insert = kind_reg == KIND_INSERT;
    assign is_remove = kind_reg == KIND_REMOVE;
    assign is_lookup = kind_reg == KIND_LOOKUP;
    assign hit_any   = match_chain[TABLE_DEPTH];
    assign hit_value = sel_chain[TABLE_DEPTH];
    assign ins_ok    = is_insert && !full;
    assign rem_ok    = is_remove && hit_any;

    always_comb
    begin
        ctrl.capture   = accept;
        ctrl.probe_key = req.key;
        ctrl.do_insert = commit && ins_ok;
        ctrl.do_remove = commit && rem_ok;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ins_ok)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (rem_ok)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (commit)
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign match_chain[0] = 1'b0;
    assign sel_chain[0]   = '0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic [KEY_W-1:0]   newer_key;
        logic [VALUE_W-1:0] newer_value;
        logic [KEY_W-1:0]   older_key;
        logic [VALUE_W-1:0] older_value;

        if (i == 0)
        begin : g_front
            assign newer_key   = key_reg;
            assign newer_value = value_reg;
        end
        else
        begin : g_mid
            assign newer_key   = cell_key[i-1];
            assign newer_value = cell_value[i-1];
        end

        if (i == TABLE_DEPTH - 1)
        begin : g_back
            assign older_key   = cell_key[i];
            assign older_value = cell_value[i];
        end
        else
        begin : g_inner
            assign older_key   = cell_key[i+1];
            assign older_value = cell_value[i+1];
        end

        krft_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .IDX         (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .count       (cnt_reg),
            .newer_key   (newer_key),
            .newer_value (newer_value),
            .older_key   (older_key),
            .older_value (older_value),
            .match_in    (match_chain[i]),
            .sel_in      (sel_chain[i]),
            .match_out   (match_chain[i+1]),
            .sel_out     (sel_chain[i+1]),
            .key         (cell_key[i]),
            .value       (cell_value[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            found_reg       <= ins_ok || ((is_remove || is_lookup) && hit_any);
            found_value_reg <= ins_ok ? value_reg
                             : ((is_remove || is_lookup) ? hit_value : '0);
            entry_count_reg <= COUNT_W'(cnt_next);
            overflow_reg    <= is_insert && full;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = found_reg;
    assign rsp.found_value = found_value_reg;
    assign rsp.entry_count = entry_count_reg;
    assign rsp.overflow    = overflow_reg;

endmodule

@@ rtl/krft_cell.sv @@
// One table slot: holds a key and value, compares against the probe key,
// forwards the newest-match chain and shifts with its neighbors. Depends on krft_pkg.
module krft_cell
    import krft_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int IDX         = 0,
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic [CNT_W-1:0]   count,
    input  logic [KEY_W-1:0]   newer_key,
    input  logic [VALUE_W-1:0] newer_value,
    input  logic [KEY_W-1:0]   older_key,
    input  logic [VALUE_W-1:0] older_value,
    input  logic               match_in,
    input  logic [VALUE_W-1:0] sel_in,
    output logic               match_out,
    output logic [VALUE_W-1:0] sel_out,
    output logic [KEY_W-1:0]   key,
    output logic [VALUE_W-1:0] value
);

    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               hit_reg;
    logic               occupied;
    logic               first;

    assign occupied = CNT_W'(IDX) < count;
    assign first    = hit_reg & ~match_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctrl.capture)
        begin
            hit_reg <= occupied && (key_reg == ctrl.probe_key);
        end
    end

    // shift toward older on insert, pull from older on remove at and past the match
    always_ff @(posedge clk)
    begin
        if (ctrl.do_insert)
        begin
            key_reg   <= newer_key;
            value_reg <= newer_value;
        end
        else if (ctrl.do_remove && (match_in || hit_reg))
        begin
            key_reg   <= older_key;
            value_reg <= older_value;
        end
    end

    assign match_out = match_in | hit_reg;
    assign sel_out   = sel_in | (first ? value_reg : '0);
    assign key       = key_reg;
    assign value     = value_reg;

endmodule

@@ rtl/krft_checker.sv @@
// Port-level checks for keyed_recent_first_table, bound to the top level.
// Depends on krft_pkg and keyed_recent_first_table_macros.svh.
`include "keyed_recent_first_table_macros.svh"

module krft_checker
    import krft_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic               found,
    input logic [VALUE_W-1:0] found_value,
    input logic [COUNT_W-1:0] entry_count,
    input logic               overflow
);

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(TABLE_DEPTH);

    `KRFT_ASSERT_NOW(a_no_found_with_overflow, rsp_valid, !(found && overflow), "found with overflow")
    `KRFT_ASSERT_NOW(a_miss_value_zero, rsp_valid && !found, found_value == '0, "miss with nonzero value")
    `KRFT_ASSERT_NOW(a_overflow_full, rsp_valid && overflow, entry_count == FULL_COUNT, "overflow while not full")
    `KRFT_ASSERT_NEXT(a_one_request_in_flight, req_valid && req_ready, !req_ready, "request taken back to back")
    `KRFT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(found_value), "response dropped while stalled")

endmodule

bind keyed_recent_first_table krft_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_krft_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .found       (rsp.found),
    .found_value (rsp.found_value),
    .entry_count (rsp.entry_count),
    .overflow    (rsp.overflow)
);

@@ tb/keyed_recent_first_table_test.sv @@
// Testbench for keyed_recent_first_table: directed and random table requests
// checked against a shadow table held in a scoreboard class.
// Depends on krft_pkg, krft_req_if, krft_rsp_if and the block itself.
`timescale 1ns / 1ps

module keyed_recent_first_table_test;
    import krft_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int POOL_SIZE    = 6;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] found_value;
        logic [COUNT_W-1:0] entry_count;
        logic               overflow;
    } table_result_t;

    class table_scoreboard;
        logic [KEY_W-1:0]   row_key[DEPTH];
        logic [VALUE_W-1:0] row_value[DEPTH];
        int                 held;
        table_result_t      awaited[$];
        int                 mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        task report_mismatch(string what, logic [VALUE_W-1:0] got,
                             logic [VALUE_W-1:0] want);
            $display("mismatch on %s: got %0h, expected %0h", what, got, want);
            mismatches++;
        endtask

        function void note_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                   logic [VALUE_W-1:0] value);
            table_result_t res;
            int            pos;
            res = '0;
            pos = held;
            case (kind)
                KIND_INSERT:
                begin
                    if (held >= DEPTH)
                        res.overflow = 1'b1;
                    else
                    begin
                        for (int i = held; i > 0; i--)
                        begin
                            row_key[i]   = row_key[i-1];
                            row_value[i] = row_value[i-1];
                        end
                        row_key[0]      = key;
                        row_value[0]    = value;
                        held++;
                        res.found       = 1'b1;
                        res.found_value = value;
                    end
                end
                KIND_REMOVE, KIND_LOOKUP:
                begin
                    for (int i = held - 1; i >= 0; i--)
                        if (row_key[i] == key)
                            pos = i;
                    if (pos < held)
                    begin
                        res.found       = 1'b1;
                        res.found_value = row_value[pos];
                        if (kind == KIND_REMOVE)
                        begin
                            for (int i = pos; i + 1 < held; i++)
                            begin
                                row_key[i]   = row_key[i+1];
                                row_value[i] = row_value[i+1];
                            end
                            held--;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            res.entry_count = COUNT_W'(held);
            awaited.push_back(res);
        endfunction

        task check_result(table_result_t got);
            table_result_t want;
            if (awaited.size() == 0)
            begin
                report_mismatch("unrequested result", got.found_value, '0);
                return;
            end
            want = awaited.pop_front();
            if (got.found !== want.found)
                report_mismatch("found", VALUE_W'(got.found), VALUE_W'(want.found));
            if (got.found_value !== want.found_value)
                report_mismatch("found_value", got.found_value, want.found_value);
            if (got.entry_count !== want.entry_count)
                report_mismatch("entry_count", VALUE_W'(got.entry_count),
                                VALUE_W'(want.entry_count));
            if (got.overflow !== want.overflow)
                report_mismatch("overflow", VALUE_W'(got.overflow),
                                VALUE_W'(want.overflow));
        endtask
    endclass

    logic clk;
    logic rst_n;

    krft_req_if req_ch();
    krft_rsp_if rsp_ch();

    keyed_recent_first_table #(.TABLE_DEPTH(DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    table_scoreboard  sb = new();
    logic [KEY_W-1:0] key_pool[POOL_SIZE];
    int               quiet_cycles = 0;
    int               ready_left = 0;
    int               stall_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (ready_left == 0 && stall_left == 0)
        begin
            ready_left = $urandom_range(1, 40);
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (ready_left > 0)
        begin
            ready_left--;
            rsp_ch.ready <= 1'b1;
        end
        else
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.kind, req_ch.key, req_ch.value);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result({rsp_ch.found, rsp_ch.found_value,
                                 rsp_ch.entry_count, rsp_ch.overflow});
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [KEY_W-1:0] key,
                                input logic [VALUE_W-1:0] value);
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.key   <= key;
        req_ch.value <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 80)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return KEY_W'($urandom);
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(input int insert_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return KIND_UNUSED;
        if (roll < 3 + insert_pct)
            return KIND_INSERT;
        return $urandom_range(0, 1) ? KIND_REMOVE : KIND_LOOKUP;
    endfunction

    initial
    begin
        logic [KIND_W-1:0] next_kind;
        int                sent;
        int                burst;
        int                insert_pct;
        int                segment_left;
        bit                paused;

        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.kind  <= KIND_INSERT;
        req_ch.key   <= '0;
        req_ch.value <= '0;
        foreach (key_pool[i])
            key_pool[i] = KEY_W'($urandom);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(KIND_LOOKUP, 16'h0000, 32'h0);
        send_request(KIND_REMOVE, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(KIND_UNUSED, 16'h0000, 32'h0);
        send_request(KIND_INSERT, 16'h0000, 32'h0000_0000);
        send_request(KIND_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, 16'h0000, 32'h1234_5678);
        send_request(KIND_LOOKUP, 16'h0000, 32'h0);
        send_request(KIND_REMOVE, 16'h0000, 32'h0);
        send_request(KIND_LOOKUP, 16'h0000, 32'h0);
        send_request(KIND_LOOKUP, 16'h1234, 32'h0);
        send_request(KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < DEPTH - 2; i++)
            send_request(KIND_INSERT, KEY_W'($urandom), $urandom);
        send_request(KIND_INSERT, 16'hA5A5, 32'hDEAD_BEEF);
        send_request(KIND_REMOVE, 16'hFFFF, 32'h0);
        send_request(KIND_REMOVE, 16'h0000, 32'h0);

        drain_results();

        sent = 0;
        segment_left = 0;
        insert_pct = 45;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            if (segment_left <= 0)
            begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 75;
                    1: insert_pct = 15;
                    default: insert_pct = 45;
                endcase
                segment_left = $urandom_range(20, 80);
            end
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                next_kind = pick_kind(insert_pct);
                send_request(next_kind, pick_key(), $urandom);
                if (next_kind != KIND_UNUSED)
                    sent++;
                if ($urandom_range(0, 49) == 0)
                    key_pool[$urandom_range(0, POOL_SIZE - 1)] = KEY_W'($urandom);
            end
            segment_left -= burst;
            if (!paused && sent >= RANDOM_ITEMS / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            else
                pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
